[rtl/core/mh64_pkg.sv]
// Package with the constants, types and mixing function of the MurmurHash64B block.
package mh64_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned HASH_W       = 64;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [WORD_W-1:0] MIX_MUL    = 32'h5bd1_e995;
  localparam int unsigned       MIX_SHIFT  = 24;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd1257785213;
  localparam int unsigned       FIN_SHIFT1 = 18;
  localparam int unsigned       FIN_SHIFT2 = 22;
  localparam int unsigned       FIN_SHIFT3 = 17;
  localparam int unsigned       FIN_SHIFT4 = 19;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FULL,
    KIND_PART
  } kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] init_h1;
    logic              start;
    kind_t             kind;
    logic              to_h2;
    logic              last;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_H,
    ST_PART,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4
  } back_state_t;

  function automatic logic [WORD_W-1:0] mul_m(input logic [WORD_W-1:0] x);
    mul_m = x * MIX_MUL;
  endfunction

endpackage

[rtl/core/mh64_ifs.sv]
// Valid/ready channel interfaces for the input, result and configuration words.
interface mh64_in_if import mh64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic [WORD_W-1:0] key_length;
  logic              last_word;

  modport source (output valid, output data_word, output key_length, output last_word,
                  input ready);
  modport sink (input valid, input data_word, input key_length, input last_word,
                output ready);
endinterface

interface mh64_out_if import mh64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

interface mh64_cfg_if import mh64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

[rtl/core/mh64_front.sv]
// Front end: seed register, key length bookkeeping and classification of each word.
module mh64_front import mh64_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  mh64_cfg_if.sink       cfg_chan,
  mh64_in_if.sink        in_chan,
  input  logic           q_full,
  output logic           q_push,
  output entry_t         q_entry
);

  logic [WORD_W-1:0] seed_r;
  logic              in_key_r, in_key_nxt;
  logic [WORD_W-1:0] bytes_left_r, bytes_left_nxt;
  logic              odd_r, odd_nxt;

  logic              accept;
  logic              start;
  logic [WORD_W-1:0] bl;
  logic              odd;
  logic [WORD_W-1:0] mask;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !q_full;
  assign accept         = in_chan.valid && !q_full;

  always_comb begin
    start = !in_key_r;
    bl    = start ? in_chan.key_length : bytes_left_r;
    odd   = start ? 1'b0 : odd_r;
    case (bl[1:0])
      2'd1:    mask = 32'h0000_00ff;
      2'd2:    mask = 32'h0000_ffff;
      2'd3:    mask = 32'h00ff_ffff;
      default: mask = '0;
    endcase

    q_entry.word    = in_chan.data_word;
    q_entry.init_h1 = seed_r ^ in_chan.key_length;
    q_entry.start   = start;
    q_entry.to_h2   = odd;
    q_entry.last    = in_chan.last_word;
    bytes_left_nxt  = bl;
    odd_nxt         = odd;
    if (bl >= WORD_W'(4)) begin
      q_entry.kind   = KIND_FULL;
      bytes_left_nxt = bl - WORD_W'(4);
      odd_nxt        = !odd;
    end else if (bl != '0) begin
      q_entry.kind   = KIND_PART;
      q_entry.word   = in_chan.data_word & mask;
      bytes_left_nxt = '0;
    end else begin
      q_entry.kind   = KIND_NONE;
    end
    in_key_nxt = 1'b1;
    if (in_chan.last_word) begin
      in_key_nxt     = 1'b0;
      bytes_left_nxt = '0;
      odd_nxt        = 1'b0;
    end
    q_push = accept && (q_entry.kind != KIND_NONE || in_chan.last_word || start);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= SEED_RESET;
      in_key_r     <= 1'b0;
      bytes_left_r <= '0;
      odd_r        <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        seed_r <= cfg_chan.seed;
      end
      if (accept) begin
        in_key_r     <= in_key_nxt;
        bytes_left_r <= bytes_left_nxt;
        odd_r        <= odd_nxt;
      end
    end
  end

endmodule

[rtl/core/mh64_fifo.sv]
// Short register queue that carries classified words from the front to the back end.
module mh64_fifo import mh64_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t pop_entry
);

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full      = count_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_entry = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (FIFO_AW+1)'(1);
        2'b01:   count_r <= count_r - (FIFO_AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/core/mh64_back.sv]
// Back end: sequencer around one shared multiply by the mixing constant, with result register.
module mh64_back import mh64_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  entry_t    q_entry,
  output logic      q_pop,
  mh64_out_if.source out_chan
);

  back_state_t       st_r, st_nxt;
  entry_t            cur_r;
  logic [WORD_W-1:0] h1_r, h1_nxt;
  logic [WORD_W-1:0] h2_r, h2_nxt;
  logic [WORD_W-1:0] k_r, k_nxt;
  logic              out_valid_r;
  logic [HASH_W-1:0] out_hash_r;
  logic [WORD_W-1:0] mul_in;
  logic [WORD_W-1:0] mul_out;
  logic              out_free;
  logic              out_load;

  assign out_free        = !out_valid_r || out_chan.ready;
  assign mul_out         = mul_m(mul_in);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.hash_value = out_hash_r;

  always_comb begin
    st_nxt   = st_r;
    h1_nxt   = h1_r;
    h2_nxt   = h2_r;
    k_nxt    = k_r;
    mul_in   = '0;
    q_pop    = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_entry.start) begin
            h1_nxt = q_entry.init_h1;
            h2_nxt = '0;
          end
          unique case (q_entry.kind)
            KIND_FULL: st_nxt = ST_K1;
            KIND_PART: st_nxt = ST_PART;
            default:   st_nxt = q_entry.last ? ST_F1 : ST_IDLE;
          endcase
        end
      end
      ST_K1: begin
        mul_in = cur_r.word;
        k_nxt  = mul_out;
        st_nxt = ST_K2;
      end
      ST_K2: begin
        mul_in = k_r ^ (k_r >> MIX_SHIFT);
        k_nxt  = mul_out;
        st_nxt = ST_H;
      end
      ST_H: begin
        if (cur_r.to_h2) begin
          mul_in = h2_r;
          h2_nxt = mul_out ^ k_r;
        end else begin
          mul_in = h1_r;
          h1_nxt = mul_out ^ k_r;
        end
        st_nxt = cur_r.last ? ST_F1 : ST_IDLE;
      end
      ST_PART: begin
        mul_in = h2_r ^ cur_r.word;
        h2_nxt = mul_out;
        st_nxt = cur_r.last ? ST_F1 : ST_IDLE;
      end
      ST_F1: begin
        mul_in = h1_r ^ (h2_r >> FIN_SHIFT1);
        h1_nxt = mul_out;
        st_nxt = ST_F2;
      end
      ST_F2: begin
        mul_in = h2_r ^ (h1_r >> FIN_SHIFT2);
        h2_nxt = mul_out;
        st_nxt = ST_F3;
      end
      ST_F3: begin
        mul_in = h1_r ^ (h2_r >> FIN_SHIFT3);
        h1_nxt = mul_out;
        st_nxt = ST_F4;
      end
      ST_F4: begin
        mul_in = h2_r ^ (h1_r >> FIN_SHIFT4);
        if (out_free) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    k_r  <= k_nxt;
    if (q_pop) begin
      cur_r <= q_entry;
    end
    if (out_load) begin
      out_hash_r <= {h1_r, mul_out};
    end
  end

endmodule

[rtl/core/murmur_hash_64b_top.sv]
// Top level of the MurmurHash64B block: front end, word queue and back end.
//
//   channel    role    carries
//   in_chan    sink    data_word, key_length, last_word
//   out_chan   source  hash_value
//   cfg_chan   sink    seed
//
// The front end takes one word per cycle while the four-entry queue has room.
// In the back end a full word passes through ST_K1, ST_K2 and ST_H, a partial word
// through ST_PART, a word that adds no bytes only through ST_IDLE, and the last
// word then through ST_F1 to ST_F4 for finalization; these steps share the one multiplier by the mixing constant.
// Reset is synchronous and active low; the seed returns to its default value.
// A stalled result holds in the output register while the back end waits.
module murmur_hash_64b_top import mh64_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mh64_in_if.sink     in_chan,
  mh64_out_if.source  out_chan,
  mh64_cfg_if.sink    cfg_chan
);

  logic   q_full;
  logic   q_push;
  entry_t q_push_entry;
  logic   q_pop;
  logic   q_not_empty;
  entry_t q_pop_entry;

  mh64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_push_entry)
  );

  mh64_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (q_pop_entry)
  );

  mh64_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_not_empty),
    .q_entry  (q_pop_entry),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

[sim/murmur_hash_64b_top_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench that streams directed and random keys through the MurmurHash64B block.
module murmur_hash_64b_top_test;
  import mh64_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned RANDOM_PHASES = 8;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] len;
    logic              last;
  } key_word_t;

  logic clk;
  logic rst_n;

  mh64_in_if  in_chan();
  mh64_out_if out_chan();
  mh64_cfg_if cfg_chan();

  murmur_hash_64b_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  key_word_t         word_queue[$];
  logic [HASH_W-1:0] hash_expected[$];
  key_word_t         word_now;
  logic [HASH_W-1:0] hash_want;

  logic [WORD_W-1:0] seed_now  = SEED_RESET;
  logic [WORD_W-1:0] h1_acc    = '0;
  logic [WORD_W-1:0] h2_acc    = '0;
  logic [WORD_W-1:0] bytes_rem = '0;
  logic              h2_turn   = 1'b0;
  logic              key_open  = 1'b0;

  int unsigned words_queued   = 0;
  int unsigned words_accepted = 0;
  int unsigned failures       = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  bit          no_idle        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("murmur_hash_64b_top_test failed");
      $finish;
    end
  end

  function automatic void absorb_word(input key_word_t kw);
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] f1;
    logic [WORD_W-1:0] f2;
    if (!key_open) begin
      h1_acc    = seed_now ^ kw.len;
      h2_acc    = '0;
      bytes_rem = kw.len;
      h2_turn   = 1'b0;
      key_open  = 1'b1;
    end
    if (bytes_rem >= 4) begin
      k = kw.word * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      if (h2_turn) begin
        h2_acc = (h2_acc * MIX_MUL) ^ k;
      end else begin
        h1_acc = (h1_acc * MIX_MUL) ^ k;
      end
      h2_turn   = ~h2_turn;
      bytes_rem = bytes_rem - 4;
    end else if (bytes_rem != 0) begin
      h2_acc    = (h2_acc ^ (kw.word & ~({WORD_W{1'b1}} << (8 * bytes_rem)))) * MIX_MUL;
      bytes_rem = '0;
    end
    if (kw.last) begin
      f1 = h1_acc;
      f2 = h2_acc;
      f1 = (f1 ^ (f2 >> FIN_SHIFT1)) * MIX_MUL;
      f2 = (f2 ^ (f1 >> FIN_SHIFT2)) * MIX_MUL;
      f1 = (f1 ^ (f2 >> FIN_SHIFT3)) * MIX_MUL;
      f2 = (f2 ^ (f1 >> FIN_SHIFT4)) * MIX_MUL;
      hash_expected.push_back({f1, f2});
      h1_acc    = '0;
      h2_acc    = '0;
      bytes_rem = '0;
      h2_turn   = 1'b0;
      key_open  = 1'b0;
    end
  endfunction

  function automatic int unsigned items_for(input logic [WORD_W-1:0] len);
    return (len == 0) ? 1 : (len + 3) / 4;
  endfunction

  task automatic push_word(input logic [WORD_W-1:0] w, input logic [WORD_W-1:0] len,
                           input logic last);
    word_queue.push_back('{word: w, len: len, last: last});
    words_queued++;
  endtask

  task automatic queue_key(input logic [WORD_W-1:0] len, input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      push_word($urandom, (i == 0) ? len : $urandom, i == n_items - 1);
    end
  endtask

  task automatic queue_random_keys(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    logic [WORD_W-1:0] len;
    start = words_queued;
    while (words_queued - start < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        len = (pick == 0) ? $urandom_range(25, 160) : $urandom_range(0, 24);
        queue_key(len, items_for(len));
      end else if (pick < 16) begin
        len = $urandom_range(0, 16);
        queue_key(len, items_for(len) + $urandom_range(1, 3));
      end else if (pick < 18) begin
        len = $urandom;
        queue_key(len, $urandom_range(1, 4));
      end else begin
        len = $urandom_range(8, 40);
        queue_key(len, $urandom_range(1, items_for(len) - 1));
      end
    end
  endtask

  task automatic wait_for_idle();
    @(posedge clk);
    while (words_accepted != words_queued || hash_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.seed  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    seed_now = value;
    cfg_chan.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        absorb_word(word_now);
        words_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (word_queue.size() != 0) begin
          word_now = word_queue.pop_front();
          in_chan.valid      <= 1'b1;
          in_chan.data_word  <= word_now.word;
          in_chan.key_length <= word_now.len;
          in_chan.last_word  <= word_now.last;
          if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 13);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (hash_expected.size() == 0) begin
          $error("hash_value: expected none, actual %h", out_chan.hash_value);
          failures++;
        end else begin
          hash_want = hash_expected.pop_front();
          if (out_chan.hash_value !== hash_want) begin
            $error("hash_value: expected %h, actual %h", hash_want, out_chan.hash_value);
            failures++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_chan.valid      = 1'b0;
    in_chan.data_word  = '0;
    in_chan.key_length = '0;
    in_chan.last_word  = 1'b0;
    out_chan.ready     = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.seed      = '0;
    rst_n              = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    push_word(32'hffff_ffff, 32'd0, 1'b1);
    push_word(32'hffff_ffff, 32'd1, 1'b1);
    push_word($urandom, 32'd2, 1'b1);
    push_word(32'hffff_ffff, 32'd3, 1'b1);
    push_word(32'h0000_0000, 32'd4, 1'b1);
    push_word(32'hffff_ffff, 32'd4, 1'b1);
    push_word($urandom, 32'd7, 1'b0);
    push_word(32'hffff_ffff, $urandom, 1'b1);
    push_word($urandom, 32'd4, 1'b0);
    push_word($urandom, $urandom, 1'b0);
    push_word($urandom, $urandom, 1'b0);
    push_word($urandom, $urandom, 1'b1);
    push_word($urandom, 32'hffff_ffff, 1'b0);
    push_word($urandom, $urandom, 1'b1);
    // The seed is rewritten while this key is still open and must only affect the next key.
    push_word(32'h0123_4567, 32'd8, 1'b0);
    wait_for_idle();
    write_seed(32'h0000_0000);
    push_word(32'h89ab_cdef, $urandom, 1'b1);
    queue_key(32'd0, 1);
    queue_key(32'd11, 3);
    wait_for_idle();
    write_seed(32'hffff_ffff);
    queue_key(32'd0, 1);
    queue_key(32'd8, 2);
    queue_key(32'd5, 2);

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_idle();
      write_seed($urandom);
      if (p == 1) begin
        hold_requests++;
      end
      if (p == RANDOM_PHASES - 1) begin
        no_idle = 1'b1;
      end
      queue_random_keys(RANDOM_ITEMS / RANDOM_PHASES);
    end
    wait_for_idle();

    if (failures == 0) begin
      $display("murmur_hash_64b_top_test passed");
    end else begin
      $display("murmur_hash_64b_top_test failed");
    end
    $finish;
  end

endmodule
